// ----- hw/rtl/apus_pkg.sv -----
// shared constants and types for the agent priority update and sort block
`default_nettype none

package apus_pkg;

   // default sizes handed to the top level parameters
   localparam int MAX_AGENTS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;

   // fixed field widths
   localparam int DIST_W  = 16;
   localparam int PRIO_W  = 32;
   localparam int IDX_W   = 6;
   localparam int COUNT_W = 7;

   // divider resolves this many quotient bits per cycle
   localparam int DIV_STEPS = 8;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 1;
   localparam logic [REG_IDX_W-1:0] REG_AGENT_COUNT = 1'b0;

   // per-cycle command broadcast along the chain
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/apus_cell.sv -----
// one cell of the sorted chain: holds one priority and its agent index
`default_nettype none

module apus_cell (
   input  wire                            clock,
   input  apus_pkg::cell_ctl_type         ctl,
   input  wire                            occupied,
   input  wire  [apus_pkg::PRIO_W-1:0]    new_prio,
   input  wire  [apus_pkg::IDX_W-1:0]     new_idx,
   input  wire                            left_keep,
   input  wire  [apus_pkg::PRIO_W-1:0]    left_prio,
   input  wire  [apus_pkg::IDX_W-1:0]     left_idx,
   input  wire  [apus_pkg::PRIO_W-1:0]    right_prio,
   input  wire  [apus_pkg::IDX_W-1:0]     right_idx,
   output logic                           keep,
   output logic [apus_pkg::PRIO_W-1:0]    prio,
   output logic [apus_pkg::IDX_W-1:0]     idx
);

   logic [apus_pkg::PRIO_W-1:0] prio_ff, prio_in;
   logic [apus_pkg::IDX_W-1:0]  idx_ff, idx_in;

   // entry stays put when it ranks ahead of or equal to the new item
   assign keep = occupied && (prio_ff >= new_prio);

   // insert: hold, take the new item, or take the left neighbor; drain: pull from right
   always_comb begin
      prio_in = prio_ff;
      idx_in  = idx_ff;
      if (ctl.insert) begin
         if (!keep) begin
            if (left_keep) begin
               prio_in = new_prio;
               idx_in  = new_idx;
            end else begin
               prio_in = left_prio;
               idx_in  = left_idx;
            end
         end
      end else if (ctl.shift) begin
         prio_in = right_prio;
         idx_in  = right_idx;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      idx_ff  <= idx_in;
   end

   assign prio = prio_ff;
   assign idx  = idx_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/apus_div.sv -----
// radix-2 divider for root priorities, several quotient bits per cycle
`default_nettype none

module apus_div #(
   parameter int FRAC_BITS = apus_pkg::FRAC_BITS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire  [apus_pkg::DIST_W-1:0]    dividend,
   input  wire  [apus_pkg::COUNT_W-1:0]   divisor,
   output logic                           done,
   output logic [apus_pkg::PRIO_W-1:0]    quotient
);

   localparam int DW     = apus_pkg::DIST_W + FRAC_BITS;
   localparam int STEPS  = apus_pkg::DIV_STEPS;
   localparam int NCYC   = (DW + STEPS - 1) / STEPS;
   localparam int NB     = NCYC * STEPS;
   localparam int CNT_W  = $clog2(NCYC + 1);
   localparam int NB_EXT = (NB > apus_pkg::PRIO_W) ? NB : apus_pkg::PRIO_W + 1;
   localparam int RW     = apus_pkg::COUNT_W;

   logic [NB-1:0]    work_ff, work_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic [RW-1:0]    div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [NB-1:0]     step_w;
   logic [RW-1:0]     step_r;
   logic [RW:0]       trial;
   logic [NB_EXT-1:0] q_ext;

   // shift-subtract steps of one cycle on the narrow remainder
   always_comb begin
      step_w = work_ff;
      step_r = rem_ff;
      trial  = '0;
      for (int s = 0; s < STEPS; s++) begin
         trial  = {step_r, step_w[NB-1]};
         step_w = {step_w[NB-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial     = trial - {1'b0, div_ff};
            step_w[0] = 1'b1;
         end
         step_r = trial[RW-1:0];
      end
   end

   // load on start, iterate while busy
   always_comb begin
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = NB'(dividend) << FRAC_BITS;
         rem_in  = '0;
         div_in  = (divisor == '0) ? RW'(1) : divisor;
         cnt_in  = CNT_W'(NCYC);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = step_w;
         rem_in  = step_r;
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // saturate quotients that do not fit the priority word
   assign q_ext    = NB_EXT'(work_ff);
   assign quotient = (|q_ext[NB_EXT-1:apus_pkg::PRIO_W]) ? '1 : q_ext[apus_pkg::PRIO_W-1:0];
   assign done     = done_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/agent_priority_update_sort.sv -----
// top level: priority update per agent item and insertion chain sort
// Non-root item: accepted, then inserted next cycle; no new item is accepted until the insert is done.
// Root item: accepted, divided by the 8-bit-per-cycle divider, then inserted; no new item meanwhile.
// Item past a full chain: dropped. After the last item, one result per cycle, unless rsp_ready stalls it,
// leaves the chain head through an output register, the first after the sequencer enters its drain state.
// Synchronous reset clears control, the agent count (to 1) and the fill count; cell data is not reset.
`default_nettype none

module agent_priority_update_sort #(
   parameter int MAX_AGENTS = apus_pkg::MAX_AGENTS_DEF,
   parameter int FRAC_BITS  = apus_pkg::FRAC_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // input items
   input  wire                                 req_valid,
   output logic                                req_ready,
   input  wire  [apus_pkg::DIST_W-1:0]         req_goal_distance,
   input  wire  [apus_pkg::PRIO_W-1:0]         req_parent_priority,
   input  wire                                 req_is_root,
   input  wire                                 req_last_agent,
   // result items
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic [apus_pkg::IDX_W-1:0]          rsp_agent_index,
   output logic [apus_pkg::PRIO_W-1:0]         rsp_new_priority,
   output logic                                rsp_end_of_order,
   // register port
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [apus_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire  [apus_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [apus_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int CW = $clog2(MAX_AGENTS + 1);
   localparam int PW = apus_pkg::PRIO_W;
   localparam int XW = apus_pkg::IDX_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DIV    = 2'd1;
   localparam logic [1:0] S_INSERT = 2'd2;
   localparam logic [1:0] S_DRAIN  = 2'd3;

   logic [1:0]                       state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [apus_pkg::COUNT_W-1:0]     agent_count_ff, agent_count_in;
   logic [PW-1:0]                    prio_ff, prio_in;
   logic                             last_ff, last_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [XW-1:0]                    rsp_idx_ff, rsp_idx_in;
   logic [PW-1:0]                    rsp_prio_ff, rsp_prio_in;
   logic                             rsp_end_ff, rsp_end_in;

   logic                             req_fire;
   logic                             chain_full;
   logic                             drain_take;
   logic                             div_start;
   logic                             div_done;
   logic [PW-1:0]                    div_q;
   logic [PW:0]                      plus_one;
   logic [PW-1:0]                    direct_prio;
   logic [apus_pkg::REG_IDX_W-1:0]   reg_idx;
   apus_pkg::cell_ctl_type           ctl;

   logic [MAX_AGENTS-1:0]            occ_w;
   logic [MAX_AGENTS-1:0]            keep_w;
   logic [MAX_AGENTS-1:0]            left_keep_w;
   logic [PW-1:0]                    cell_prio [MAX_AGENTS];
   logic [XW-1:0]                    cell_idx  [MAX_AGENTS];
   logic [PW-1:0]                    left_prio [MAX_AGENTS];
   logic [XW-1:0]                    left_idx  [MAX_AGENTS];
   logic [PW-1:0]                    right_prio[MAX_AGENTS];
   logic [XW-1:0]                    right_idx [MAX_AGENTS];

   // register port
   assign reg_idx    = csr_paddr[apus_pkg::CSR_ADDR_W-1:2];
   assign csr_pready = 1'b1;
   assign csr_prdata = (reg_idx == apus_pkg::REG_AGENT_COUNT) ?
                       apus_pkg::CSR_DATA_W'(agent_count_ff) : '0;
   assign agent_count_in = (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                            reg_idx == apus_pkg::REG_AGENT_COUNT) ?
                           csr_pwdata[apus_pkg::COUNT_W-1:0] : agent_count_ff;

   // handshake helpers
   assign req_ready  = (state_ff == S_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign chain_full = (count_ff == CW'(MAX_AGENTS));
   assign drain_take = (state_ff == S_DRAIN) && (count_ff != '0) &&
                       (!rsp_valid_ff || rsp_ready);
   assign div_start  = req_fire && !chain_full && req_is_root;

   // non-root priority: parent plus one, or only its fraction at the goal
   assign plus_one    = {1'b0, req_parent_priority} + ((PW + 1)'(1) << FRAC_BITS);
   assign direct_prio = (req_goal_distance != '0) ?
                        (plus_one[PW] ? '1 : plus_one[PW-1:0]) :
                        (req_parent_priority & ((PW'(1) << FRAC_BITS) - PW'(1)));

   apus_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_goal_distance),
      .divisor  (agent_count_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      prio_in  = prio_ff;
      last_in  = last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               last_in = req_last_agent;
               if (chain_full) begin
                  state_in = req_last_agent ? S_DRAIN : S_IDLE;
               end else if (req_is_root) begin
                  state_in = S_DIV;
               end else begin
                  prio_in  = direct_prio;
                  state_in = S_INSERT;
               end
            end
         end
         S_DIV: begin
            if (div_done) begin
               prio_in  = div_q;
               state_in = S_INSERT;
            end
         end
         S_INSERT: begin
            count_in = count_ff + CW'(1);
            state_in = last_ff ? S_DRAIN : S_IDLE;
         end
         S_DRAIN: begin
            if (count_ff == '0) begin
               state_in = S_IDLE;
            end else if (drain_take) begin
               count_in = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register fed from the chain head
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_end_in   = rsp_end_ff;
      if (drain_take) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = cell_idx[0];
         rsp_prio_in  = cell_prio[0];
         rsp_end_in   = (count_ff == CW'(1));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff     <= prio_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_prio_ff <= rsp_prio_in;
      rsp_end_ff  <= rsp_end_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         agent_count_ff <= apus_pkg::COUNT_W'(1);
         last_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         agent_count_ff <= agent_count_in;
         last_ff        <= last_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_agent_index  = rsp_idx_ff;
   assign rsp_new_priority = rsp_prio_ff;
   assign rsp_end_of_order = rsp_end_ff;

   // chain command
   assign ctl.insert = (state_ff == S_INSERT);
   assign ctl.shift  = drain_take;

   // the sorted chain
   for (genvar i = 0; i < MAX_AGENTS; i++) begin : g_cell
      assign occ_w[i] = (count_ff > CW'(i));

      if (i == 0) begin : g_head
         assign left_keep_w[i] = 1'b1;
         assign left_prio[i]   = prio_ff;
         assign left_idx[i]    = XW'(count_ff);
      end else begin : g_body
         assign left_keep_w[i] = keep_w[i-1];
         assign left_prio[i]   = cell_prio[i-1];
         assign left_idx[i]    = cell_idx[i-1];
      end

      if (i == MAX_AGENTS - 1) begin : g_tail
         assign right_prio[i] = cell_prio[i];
         assign right_idx[i]  = cell_idx[i];
      end else begin : g_next
         assign right_prio[i] = cell_prio[i+1];
         assign right_idx[i]  = cell_idx[i+1];
      end

      apus_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (occ_w[i]),
         .new_prio   (prio_ff),
         .new_idx    (XW'(count_ff)),
         .left_keep  (left_keep_w[i]),
         .left_prio  (left_prio[i]),
         .left_idx   (left_idx[i]),
         .right_prio (right_prio[i]),
         .right_idx  (right_idx[i]),
         .keep       (keep_w[i]),
         .prio       (cell_prio[i]),
         .idx        (cell_idx[i])
      );
   end

endmodule

`default_nettype wire

// ----- hw/rtl/apus_checker.sv -----
// port-level checks for the agent priority update and sort block
`default_nettype none

module apus_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_ready,
   input wire                                 rsp_valid,
   input wire                                 rsp_ready,
   input wire [apus_pkg::IDX_W-1:0]           rsp_agent_index,
   input wire [apus_pkg::PRIO_W-1:0]          rsp_new_priority,
   input wire                                 rsp_end_of_order,
   input wire                                 csr_psel,
   input wire                                 csr_pready
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_agent_index) &&
      $stable(rsp_new_priority) && $stable(rsp_end_of_order))
      else $error("result item changed while stalled");

   // no result item right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result item valid after reset");

   // no new input item while an order is still being drained
   a_drain_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_of_order |-> !req_ready)
      else $error("input taken in the middle of an order");

   // register port never stalls
   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel |-> csr_pready)
      else $error("register port stalled");

endmodule

bind agent_priority_update_sort apus_checker u_apus_checker (.*);

`default_nettype wire

// ----- sim/tb_agent_priority_update_sort.sv -----
// testbench for the agent priority update and sort block: random handshakes, predicted order
`timescale 1ns / 100ps

module tb_agent_priority_update_sort;

   localparam int MAX_AG        = apus_pkg::MAX_AGENTS_DEF;
   localparam int FRAC          = apus_pkg::FRAC_BITS_DEF;
   localparam int IDX_BITS      = apus_pkg::IDX_W;
   localparam int SPARE_REG_IDX = 1;
   localparam logic [apus_pkg::CSR_ADDR_W-1:0] AGENT_COUNT_ADDR =
      {apus_pkg::REG_AGENT_COUNT, 2'b00};
   localparam logic [apus_pkg::CSR_ADDR_W-1:0] SPARE_ADDR =
      apus_pkg::CSR_ADDR_W'(4 * SPARE_REG_IDX);
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES         = 7;

   typedef struct packed {
      logic [apus_pkg::DIST_W-1:0] distance;
      logic [apus_pkg::PRIO_W-1:0] parent;
      logic                        root;
      logic                        last;
   } agent_item_type;

   typedef struct packed {
      logic [apus_pkg::IDX_W-1:0]  index;
      logic [apus_pkg::PRIO_W-1:0] prio;
      logic                        closing;
   } ranked_agent_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic [apus_pkg::DIST_W-1:0]       req_goal_distance = '0;
   logic [apus_pkg::PRIO_W-1:0]       req_parent_priority = '0;
   logic                              req_is_root = 1'b0;
   logic                              req_last_agent = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [apus_pkg::IDX_W-1:0]        rsp_agent_index;
   logic [apus_pkg::PRIO_W-1:0]       rsp_new_priority;
   logic                              rsp_end_of_order;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [apus_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [apus_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [apus_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;

   // predictor state: divisor register and the sorted chain
   logic [apus_pkg::COUNT_W-1:0]      divisor_q = apus_pkg::COUNT_W'(1);
   logic [apus_pkg::PRIO_W-1:0]       chain_prio [MAX_AG];
   logic [apus_pkg::IDX_W-1:0]        chain_idx  [MAX_AG];
   int                                chain_fill = 0;

   agent_item_type                    agent_feed [$];
   ranked_agent_type                  order_expect [$];
   agent_item_type                    in_flight;
   int                                errors = 0;
   int                                idle_cycles = 0;
   int                                gap_left = 0;
   int                                stall_left = 0;
   bit                                calm = 1'b0;
   logic [apus_pkg::COUNT_W-1:0]      phase_counts [PHASES] =
      '{7'd3, 7'd1, 7'd64, 7'd0, 7'd127, 7'd0, 7'd0};

   agent_priority_update_sort u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_goal_distance   (req_goal_distance),
      .req_parent_priority (req_parent_priority),
      .req_is_root         (req_is_root),
      .req_last_agent      (req_last_agent),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_agent_index     (rsp_agent_index),
      .rsp_new_priority    (rsp_new_priority),
      .rsp_end_of_order    (rsp_end_of_order),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (errors < 100) $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   // mostly short gaps, a few long ones, none while calm
   function automatic int pick_gap();
      int roll;
      if (calm) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // new priority of one agent, insertion into the chain, order on the last agent
   task automatic rank_agent(input agent_item_type item);
      logic [63:0] q;
      int pos;
      ranked_agent_type entry;
      if (item.root)
         q = (64'(item.distance) << FRAC) /
             64'((divisor_q == '0) ? apus_pkg::COUNT_W'(1) : divisor_q);
      else if (item.distance != '0)
         q = 64'(item.parent) + (64'd1 << FRAC);
      else
         q = 64'(item.parent) & ((64'd1 << FRAC) - 64'd1);
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
      // agents past a full chain are dropped
      if (chain_fill < MAX_AG) begin
         pos = chain_fill;
         while (pos > 0 && chain_prio[pos-1] < q[31:0]) begin
            chain_prio[pos] = chain_prio[pos-1];
            chain_idx[pos]  = chain_idx[pos-1];
            pos--;
         end
         chain_prio[pos] = q[31:0];
         chain_idx[pos]  = IDX_BITS'(chain_fill);
         chain_fill++;
      end
      if (item.last) begin
         for (int k = 0; k < chain_fill; k++) begin
            entry.index   = chain_idx[k];
            entry.prio    = chain_prio[k];
            entry.closing = (k == chain_fill - 1);
            order_expect.push_back(entry);
         end
         chain_fill = 0;
      end
   endtask

   task automatic queue_item(input logic [apus_pkg::DIST_W-1:0] distance,
                             input logic [apus_pkg::PRIO_W-1:0] parent,
                             input logic root, input logic last);
      agent_item_type item;
      item.distance = distance;
      item.parent   = parent;
      item.root     = root;
      item.last     = last;
      agent_feed.push_back(item);
   endtask

   // one node of random agents, with frequent ties and extremes
   task automatic queue_node(input int agents, input bit root_node);
      agent_item_type item;
      int roll;
      for (int a = 0; a < agents; a++) begin
         roll = $urandom_range(0, 99);
         if (roll < 20)      item.distance = '0;
         else if (roll < 28) item.distance = '1;
         else if (roll < 45) item.distance = apus_pkg::DIST_W'($urandom_range(1, 4));
         else                item.distance = apus_pkg::DIST_W'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 25)      item.parent = {16'($urandom_range(0, 3)), 16'h8000};
         else if (roll < 33) item.parent = '1;
         else                item.parent = $urandom;
         item.root = ($urandom_range(0, 9) == 0) ? ~root_node : root_node;
         item.last = (a == agents - 1);
         agent_feed.push_back(item);
      end
   endtask

   // wait until everything sent has been answered, then let the block settle
   task automatic drain();
      do @(negedge clock);
      while (agent_feed.size() != 0 || req_valid || order_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register write with setup and access phases, only while the block is idle
   task automatic write_reg(input logic [apus_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [apus_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == AGENT_COUNT_ADDR) divisor_q = data[apus_pkg::COUNT_W-1:0];
   endtask

   // item driver
   always @(posedge clock) begin : driver
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            rank_agent(in_flight);
            next_valid = 1'b0;
            gap_left = pick_gap();
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (agent_feed.size() > 0) begin
               in_flight = agent_feed.pop_front();
               next_valid = 1'b1;
               req_goal_distance   <= in_flight.distance;
               req_parent_priority <= in_flight.parent;
               req_is_root         <= in_flight.root;
               req_last_agent      <= in_flight.last;
            end
         end
         req_valid <= next_valid;
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin : monitor
      ranked_agent_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (order_expect.size() == 0) begin
               report_mismatch("unexpected result, agent_index", 32'(rsp_agent_index), '0);
            end else begin
               want = order_expect.pop_front();
               if (rsp_agent_index !== want.index)
                  report_mismatch("agent_index", 32'(rsp_agent_index), 32'(want.index));
               if (rsp_new_priority !== want.prio)
                  report_mismatch("new_priority", rsp_new_priority, want.prio);
               if (rsp_end_of_order !== want.closing)
                  report_mismatch("end_of_order", 32'(rsp_end_of_order), 32'(want.closing));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_agent_priority_update_sort failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // stimulus sequence
   initial begin
      int phase_items;
      int agents;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // single root agent at maximum distance, divisor from reset
      queue_item('1, '0, 1'b1, 1'b1);
      // saturation, fractional part only, plain increment, all zero
      queue_item(16'd1, '1, 1'b0, 1'b0);
      queue_item('0, '1, 1'b0, 1'b0);
      queue_item('1, '0, 1'b0, 1'b0);
      queue_item('0, '0, 1'b0, 1'b1);
      // equal priorities from both kinds of node
      queue_item(16'd5, 32'h0002_0000, 1'b0, 1'b0);
      queue_item(16'd9, 32'h0002_0000, 1'b0, 1'b0);
      queue_item(16'd3, 32'h0000_0000, 1'b1, 1'b0);
      queue_item(16'd1, 32'h0002_0000, 1'b0, 1'b1);
      // root with zero and unit distance
      queue_item('0, 32'h1234_5678, 1'b1, 1'b0);
      queue_item(16'd1, 32'h8765_4321, 1'b1, 1'b1);
      drain();

      // zero divisor behaves as one
      write_reg(AGENT_COUNT_ADDR, 32'd0);
      queue_item(16'd7, '0, 1'b1, 1'b0);
      queue_item('1, '1, 1'b1, 1'b1);
      drain();
      write_reg(AGENT_COUNT_ADDR, 32'd64);
      queue_item('1, '0, 1'b1, 1'b0);
      queue_item(16'd63, '0, 1'b1, 1'b1);
      drain();
      write_reg(AGENT_COUNT_ADDR, 32'd127);
      queue_item(16'd200, '0, 1'b1, 1'b0);
      queue_item(16'd126, '0, 1'b1, 1'b1);
      drain();
      // write to an unused register index leaves the divisor alone
      write_reg(SPARE_ADDR, 32'd5);
      queue_item(16'd100, '0, 1'b1, 1'b1);
      drain();

      // random phases over several divisor settings
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 5) write_reg(AGENT_COUNT_ADDR, 32'(phase_counts[ph]));
         else        write_reg(AGENT_COUNT_ADDR, 32'($urandom_range(1, 64)));
         calm = (ph == 2);
         // one node past the chain capacity
         if (ph == 1) queue_node(MAX_AG + 2, 1'b0);
         phase_items = 0;
         while (phase_items < 10) begin
            agents = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            queue_node(agents, 1'($urandom_range(0, 1)));
            phase_items += agents;
         end
         drain();
      end
      calm = 1'b0;

      if (errors == 0) begin
         $display("tb_agent_priority_update_sort passed");
      end else begin
         $display("tb_agent_priority_update_sort failed");
      end
      $finish;
   end

endmodule

// ----- agent_priority_update_sort.f -----
hw/rtl/apus_pkg.sv
hw/rtl/apus_cell.sv
hw/rtl/apus_div.sv
hw/rtl/agent_priority_update_sort.sv
hw/rtl/apus_checker.sv
sim/tb_agent_priority_update_sort.sv
